[rtl/ipv4_acl_first_match_unit_defines.svh]
// Assertion macros for the IPv4 ACL first-match unit.
`ifndef IPV4_ACL_FIRST_MATCH_UNIT_DEFINES_SVH
`define IPV4_ACL_FIRST_MATCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define ACL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ACL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/acl_fm_pkg.sv]
// Shared types, constants and helpers of the IPv4 ACL first-match unit.
package acl_fm_pkg;

    localparam int MAX_RULES_DEF = 64;
    localparam int ADDR_W        = 32;
    localparam int LEN_W         = 6;
    localparam int NUM_W         = 6;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 16;

    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic MODE_ADD   = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              verdict;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] prefix;
    } rule_t;

    typedef struct packed {
        logic             status;
        logic [NUM_W-1:0] rule_number;
        logic             matched;
        logic             verdict;
    } result_t;

    // Leading-ones mask for a prefix length of 0..32.
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
        prefix_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

[rtl/ipv4_acl_first_match_unit.sv]
// IPv4 access-control list with ordered first-match lookup (top level).
//
// Rules live in a single-port-read, single-port-write synchronous table of
// MAX_RULES entries (prefix, length, verdict), appended in order by add
// requests (s_tuser = 0). A query request (s_tuser = 1) walks the table from
// rule 0 upward, one table read per cycle, and the first rule whose leading
// prefix bits equal the address decides; with no hit, default_allow (written
// through the cfg port, resets to allow) gives the verdict. A query scans
// until the hit or the end of the table; on an empty table it skips the
// scan. A finished response sits in the output register until taken,
// while the next request is already accepted and worked on. An add to a
// full table drops the rule and answers with status 1. Prefix lengths above
// 32 are stored as 32. No clearing pass: entries past the rule count are
// never read, so the block is ready right after reset.
`include "ipv4_acl_first_match_unit_defines.svh"

module ipv4_acl_first_match_unit #(
    parameter int MAX_RULES = acl_fm_pkg::MAX_RULES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // request: [31:0] address, [37:32] prefix_len, [38] allow, [39] zero
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [acl_fm_pkg::IN_DATA_W-1:0]  s_tdata,
    // request: [0] mode (0 add, 1 query)
    input  logic                              s_tuser,
    // response: [0] verdict, [1] matched, [7:2] rule_number, [8] status, [15:9] zero
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [acl_fm_pkg::OUT_DATA_W-1:0] m_tdata,
    // default_allow register write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data
);

    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int NUM_W = acl_fm_pkg::NUM_W;

    // Control state
    acl_fm_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;      // stored rule count
    logic [IDX_W-1:0]   idx_reg, idx_next;      // rule under compare in SCAN
    logic               out_valid_reg, out_valid_next;
    logic               dflt_reg, dflt_next;    // default_allow

    // Payload
    logic [acl_fm_pkg::ADDR_W-1:0] qaddr_reg, qaddr_next;
    acl_fm_pkg::result_t           res_reg, res_next;
    acl_fm_pkg::result_t           out_data_reg, out_data_next;

    // Rule table
    acl_fm_pkg::rule_t mem [MAX_RULES];
    acl_fm_pkg::rule_t rd_data_reg;
    acl_fm_pkg::rule_t wr_rule;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;

    // Decode / status
    logic                          in_fire;
    logic                          in_mode;
    logic [acl_fm_pkg::ADDR_W-1:0] in_addr;
    logic [acl_fm_pkg::LEN_W-1:0]  in_len;
    logic [acl_fm_pkg::LEN_W-1:0]  len_sat;
    logic                          in_allow;
    logic                          full;
    logic                          hit;
    logic                          last;
    logic                          load_out;
    logic [IDX_W-1:0]              cnt_idx;
    logic [IDX_W+NUM_W-1:0]        add_num_ext;
    logic [IDX_W+NUM_W-1:0]        hit_num_ext;

    // ------------------------------------------------------------------
    // Handshake outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready = (state_reg == acl_fm_pkg::ST_IDLE);
        load_out = (state_reg == acl_fm_pkg::ST_DONE) && (!out_valid_reg || m_tready);
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(acl_fm_pkg::OUT_DATA_W - $bits(acl_fm_pkg::result_t)){1'b0}},
                        out_data_reg};

    // ------------------------------------------------------------------
    // Request decode and compare
    // ------------------------------------------------------------------
    always_comb
    begin
        in_fire  = s_tvalid && s_tready;
        in_mode  = s_tuser;
        in_addr  = s_tdata[31:0];
        in_len   = s_tdata[37:32];
        in_allow = s_tdata[38];
        len_sat  = (in_len > acl_fm_pkg::MAX_LEN) ? acl_fm_pkg::MAX_LEN : in_len;

        full    = (cnt_reg == CNT_W'(MAX_RULES));
        cnt_idx = cnt_reg[IDX_W-1:0];

        // A rule of length 0 has an all-zero mask and matches anything.
        hit  = ((rd_data_reg.prefix ^ qaddr_reg)
                & acl_fm_pkg::prefix_mask(rd_data_reg.length)) == '0;
        last = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);

        // Rule numbers report the low bits of the table index.
        add_num_ext = {{NUM_W{1'b0}}, cnt_idx};
        hit_num_ext = {{NUM_W{1'b0}}, idx_reg};
    end

    // ------------------------------------------------------------------
    // FSM next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            acl_fm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_mode == acl_fm_pkg::MODE_QUERY && cnt_reg != '0)
                        state_next = acl_fm_pkg::ST_SCAN;
                    else
                        state_next = acl_fm_pkg::ST_DONE;
                end
            end
            acl_fm_pkg::ST_SCAN:
            begin
                if (hit || last)
                    state_next = acl_fm_pkg::ST_DONE;
            end
            acl_fm_pkg::ST_DONE:
            begin
                if (load_out)
                    state_next = acl_fm_pkg::ST_IDLE;
            end
            default:
                state_next = acl_fm_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath / table control
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        qaddr_next     = qaddr_reg;
        res_next       = res_reg;
        dflt_next      = dflt_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        wr_en          = 1'b0;
        wr_addr        = cnt_idx;
        wr_rule.prefix = in_addr;
        wr_rule.length = len_sat;
        wr_rule.verdict = in_allow;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (cfg_valid && cfg_ready)
            dflt_next = cfg_data;

        unique case (state_reg)
            acl_fm_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    res_next.verdict     = 1'b0;
                    res_next.matched     = 1'b0;
                    res_next.rule_number = '0;
                    res_next.status      = acl_fm_pkg::STATUS_OK;
                    if (in_mode == acl_fm_pkg::MODE_ADD)
                    begin
                        if (full)
                            res_next.status = acl_fm_pkg::STATUS_FULL;
                        else
                        begin
                            wr_en                = 1'b1;
                            res_next.rule_number = add_num_ext[NUM_W-1:0];
                            cnt_next             = cnt_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        qaddr_next       = in_addr;
                        idx_next         = '0;
                        res_next.verdict = dflt_reg;   // empty table
                        rd_en            = 1'b1;
                        rd_addr          = '0;
                    end
                end
            end
            acl_fm_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    res_next.verdict     = rd_data_reg.verdict;
                    res_next.matched     = 1'b1;
                    res_next.rule_number = hit_num_ext[NUM_W-1:0];
                end
                else if (last)
                    res_next.verdict = dflt_reg;
                else
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + IDX_W'(1);
                end
            end
            acl_fm_pkg::ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // Output register: load a finished response, else drain on accept.
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_reg;
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acl_fm_pkg::ST_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            dflt_reg      <= 1'b1;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            dflt_reg      <= dflt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qaddr_reg    <= qaddr_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    // Rule table: one write, one registered read per cycle. Writes happen
    // only in IDLE and reads only for a query, so they never collide.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_rule;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ACL_ASSERT_NOW(a_scan_in_range, state_reg == acl_fm_pkg::ST_SCAN,
                    CNT_W'(idx_reg) < cnt_reg, "scan index past rule count")
    `ACL_ASSERT_NXT(a_add_counts, in_fire && in_mode == acl_fm_pkg::MODE_ADD && !full,
                    cnt_reg == $past(cnt_reg) + CNT_W'(1), "add did not bump rule count")
    `ACL_ASSERT_NOW(a_resp_from_done, $rose(out_valid_reg),
                    $past(state_reg) == acl_fm_pkg::ST_DONE, "response not from DONE")

endmodule

[bench/ipv4_acl_first_match_unit_tb.sv]
// Self-checking testbench for the IPv4 ACL first-match unit: rule adds, lookups, table full.
`timescale 1ns / 100ps

module ipv4_acl_first_match_unit_tb;

    localparam int CLK_HALF     = 10;
    localparam int IDLE_LIMIT   = 4000;   // cycles with no handshake at all before giving up
    localparam int LONG_HOLD    = 300;    // receiver hold-off while the sender keeps pushing
    localparam int QUIET_CYCLES = 150;    // > one full-table scan, catches stray responses
    localparam int PRINT_CAP    = 100;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              s_tvalid = 1'b0;
    logic                              s_tready;
    // request: [31:0] address, [37:32] prefix_len, [38] allow, [39] zero
    logic [acl_fm_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    // request: [0] mode (0 add, 1 query)
    logic                              s_tuser = acl_fm_pkg::MODE_ADD;
    logic                              m_tvalid;
    logic                              m_tready = 1'b0;
    // response: [0] verdict, [1] matched, [7:2] rule_number, [8] status, [15:9] zero
    logic [acl_fm_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic                              cfg_data = 1'b0;

    ipv4_acl_first_match_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: our own copy of the rule table and default verdict
    // ------------------------------------------------------------------
    logic [acl_fm_pkg::ADDR_W-1:0] acl_prefix [acl_fm_pkg::MAX_RULES_DEF];
    int                            acl_length [acl_fm_pkg::MAX_RULES_DEF];
    logic                          acl_allow  [acl_fm_pkg::MAX_RULES_DEF];
    int                            acl_rule_count = 0;
    logic                          acl_default    = 1'b1;   // comes out of reset as allow

    acl_fm_pkg::result_t pending_verdicts[$];   // responses owed by the block, oldest first
    int                  mismatch_count = 0;

    // Sender pacing: bursts of random length, gaps up to gap_max cycles.
    int burst_left = 0;
    int gap_max    = 0;

    // Bumped by a test to ask the receiver for one long hold-off.
    int hold_trigger = 0;

    // Applies one accepted request to the predicted table and returns the response.
    function automatic acl_fm_pkg::result_t acl_lookup(
        input logic                            mode,
        input logic [acl_fm_pkg::ADDR_W-1:0]   addr,
        input logic [acl_fm_pkg::LEN_W-1:0]    len,
        input logic                            alw);
        acl_fm_pkg::result_t r;
        logic [31:0]         keep;
        int                  stored_len;
        r = '0;
        if (mode == acl_fm_pkg::MODE_ADD)
        begin
            // lengths past /32 are clamped, stray prefix bits are kept as given
            stored_len = (len > acl_fm_pkg::MAX_LEN) ? int'(acl_fm_pkg::MAX_LEN) : int'(len);
            if (acl_rule_count < acl_fm_pkg::MAX_RULES_DEF)
            begin
                acl_prefix[acl_rule_count] = addr;
                acl_length[acl_rule_count] = stored_len;
                acl_allow[acl_rule_count]  = alw;
                r.rule_number = acl_fm_pkg::NUM_W'(acl_rule_count);
                r.status      = acl_fm_pkg::STATUS_OK;
                acl_rule_count++;
            end
            else
            begin
                r.status = acl_fm_pkg::STATUS_FULL;   // rule dropped, index reads 0
            end
            return r;
        end
        // first stored rule wins; /0 keeps no bits so it matches anything
        r.verdict = acl_default;
        for (int i = 0; i < acl_rule_count; i++)
        begin
            keep = '1;
            keep = keep << (32 - acl_length[i]);
            if (((acl_prefix[i] ^ addr) & keep) == '0)
            begin
                r.verdict     = acl_allow[i];
                r.matched     = 1'b1;
                r.rule_number = acl_fm_pkg::NUM_W'(i);
                return r;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    endtask

    // Offers one request, honoring the burst/gap pacing, and returns once accepted.
    task automatic send_request(input logic mode, input logic [acl_fm_pkg::ADDR_W-1:0] addr,
                                input logic [acl_fm_pkg::LEN_W-1:0] len, input logic alw);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {1'b0, alw, len, addr};
        do
            @(posedge clk);
        while (!s_tready);
        pending_verdicts.push_back(acl_lookup(mode, addr, len, alw));
    endtask

    // Sender goes quiet until the block has answered everything.
    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge clk);
    endtask

    // default_allow is only written with the block idle.
    task automatic write_default(input logic value);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid   <= 1'b0;
        acl_default = value;
    endtask

    // Rule with mostly long prefixes; some duplicates of stored prefixes, some >32 lengths.
    task automatic send_random_add();
        logic [acl_fm_pkg::ADDR_W-1:0] addr;
        logic [acl_fm_pkg::LEN_W-1:0]  len;
        int                            sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
            len = acl_fm_pkg::LEN_W'($urandom_range(33, 63));
        else if (sel < 10)
            len = acl_fm_pkg::LEN_W'($urandom_range(1, 7));
        else if (sel < 30)
            len = acl_fm_pkg::LEN_W'($urandom_range(8, 15));
        else
            len = acl_fm_pkg::LEN_W'($urandom_range(16, 32));
        addr = $urandom;
        if (acl_rule_count > 0 && acl_rule_count < acl_fm_pkg::MAX_RULES_DEF
            && $urandom_range(0, 3) == 0)
            addr = acl_prefix[$urandom_range(0, acl_rule_count - 1)];
        send_request(acl_fm_pkg::MODE_ADD, addr, len, 1'($urandom_range(0, 1)));
    endtask

    // Lookup aimed inside a stored rule most of the time, otherwise anywhere.
    task automatic send_random_query();
        logic [acl_fm_pkg::ADDR_W-1:0] addr;
        logic [31:0]                   keep;
        int                            idx;
        addr = $urandom;
        if (acl_rule_count > 0 && $urandom_range(0, 99) < 60)
        begin
            idx  = $urandom_range(0, acl_rule_count - 1);
            keep = '1;
            keep = keep << (32 - acl_length[idx]);
            addr = (acl_prefix[idx] & keep) | (addr & ~keep);
        end
        // prefix_len and allow are don't-care on a lookup; wiggle them anyway
        send_request(acl_fm_pkg::MODE_QUERY, addr, acl_fm_pkg::LEN_W'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic send_random_mix(input int count, input int add_pct);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < add_pct)
                send_random_add();
            else
                send_random_query();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty table: every lookup falls back to the default, both settings.
    task automatic test_empty_table();
        gap_max = 2;
        send_request(acl_fm_pkg::MODE_QUERY, 32'h0000_0000, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'hFFFF_FFFF, 6'd63, 1'b1);
        write_default(1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'h0000_0000, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'hC0A8_0101, 6'd0, 1'b0);
    endtask

    // Field extremes, length clamp, ignored tail bits, shadowed duplicate, misses.
    task automatic test_rule_fields();
        gap_max = 1;
        send_request(acl_fm_pkg::MODE_ADD, 32'hFFFF_FFFF, 6'd32, 1'b1);
        send_request(acl_fm_pkg::MODE_ADD, 32'h0000_0000, 6'd63, 1'b0);   // clamps to /32
        send_request(acl_fm_pkg::MODE_ADD, 32'hC0A8_FFFF, 6'd16, 1'b1);   // host bits ignored
        send_request(acl_fm_pkg::MODE_ADD, 32'hC0A8_0000, 6'd16, 1'b0);   // never decides
        send_request(acl_fm_pkg::MODE_ADD, 32'h0A00_0000, 6'd33, 1'b1);   // clamps to /32
        send_request(acl_fm_pkg::MODE_ADD, 32'hAAAA_5555, 6'd24, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'hFFFF_FFFF, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'h0000_0000, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'hC0A8_1234, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'hC0A9_1234, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'h0A00_0000, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'h0A00_0001, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'hAAAA_55FF, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'hAAAA_54FF, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'h5555_5555, 6'd0, 1'b0);
        write_default(1'b1);
        send_request(acl_fm_pkg::MODE_QUERY, 32'h7FFF_FFFF, 6'd0, 1'b0);
        send_request(acl_fm_pkg::MODE_QUERY, 32'h8000_0000, 6'd0, 1'b0);
    endtask

    // Grow the table to one short of full, lookups in between.
    task automatic test_fill_table();
        gap_max = 4;
        while (acl_rule_count < acl_fm_pkg::MAX_RULES_DEF - 1)
            send_random_mix(1, 25);
    endtask

    // Long scans with the table nearly full, misses under both defaults.
    task automatic test_deep_scan();
        write_default(1'b0);
        gap_max = 0;   // back-to-back requests, no sender idling
        repeat (150) send_random_query();
        write_default(1'b1);
        gap_max = 6;
        repeat (150) send_random_query();
    endtask

    // Receiver holds off for a long stretch; input must back up and stall.
    task automatic test_backpressure();
        gap_max = 0;
        hold_trigger <= hold_trigger + 1;
        repeat (40) send_random_query();
        wait_all_results();   // sender sits out until every response is in
    endtask

    // Last slot gets a catch-all /0 rule, then adds bounce off the full table.
    task automatic test_catch_all_and_full();
        gap_max = 3;
        send_request(acl_fm_pkg::MODE_ADD, $urandom, 6'd0, 1'($urandom_range(0, 1)));
        send_random_mix(100, 30);
    endtask

    // Bulk random traffic, default flipped between chunks, pacing varied.
    task automatic test_random_traffic();
        write_default(1'b0);
        gap_max = 0;
        send_random_mix(300, 20);
        write_default(1'b1);
        gap_max = 3;
        send_random_mix(300, 20);
        write_default(1'b0);
        gap_max = 8;
        send_random_mix(300, 20);
    endtask

    // ------------------------------------------------------------------
    // Response checker: one compare per field against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        acl_fm_pkg::result_t got;
        acl_fm_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = acl_fm_pkg::result_t'(m_tdata[$bits(acl_fm_pkg::result_t)-1:0]);
            if (pending_verdicts.size() == 0)
            begin
                report_mismatch("unexpected response, data", int'(m_tdata), 0);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.verdict !== want.verdict)
                    report_mismatch("verdict", got.verdict, want.verdict);
                if (got.matched !== want.matched)
                    report_mismatch("matched", got.matched, want.matched);
                if (got.rule_number !== want.rule_number)
                    report_mismatch("rule_number", got.rule_number, want.rule_number);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: own stall pattern that rotates styles, plus the long hold
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        static int rx_cycle  = 0;
        static int hold_seen = 0;
        static int hold_left = 0;
        int style;
        rx_cycle++;
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        style = (rx_cycle / 700) % 4;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (style == 0)
            m_tready <= 1'b1;                          // never stalls
        else if (style == 1)
            m_tready <= 1'($urandom_range(0, 1));      // coin flip
        else if (style == 2)
            m_tready <= (rx_cycle % 4 == 0);           // one in four
        else
            m_tready <= ($urandom_range(0, 9) != 0);   // rare stalls
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any handshake means the block hung
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        static int quiet = 0;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_rule_fields();
        test_fill_table();
        test_deep_scan();
        test_backpressure();
        test_catch_all_and_full();
        test_random_traffic();

        wait_all_results();
        repeat (QUIET_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
            report_mismatch("responses never delivered", 0, pending_verdicts.size());

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
